// ===== hw/rtl/ihex_pkg.sv =====
// Shared types, character codes and the hex digit decoder for the Intel HEX parser.
// Used by ihex_front, ihex_byte_q, ihex_back and intel_hex_data_extractor.
package ihex_pkg;

  // Characters that carry no digit
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  // Digit ranges
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [7:0] DIGIT_TEN = 8'd10;

  // Record types
  localparam logic [7:0] REC_DATA = 8'h00;
  localparam logic [7:0] REC_EOF  = 8'h01;

  // One decoded byte passed from the front to the back
  typedef struct packed {
    logic [7:0] value;
    logic       bad;
  } byte_beat_t;

  // One result beat
  typedef struct packed {
    logic [7:0]  data_byte;
    logic [15:0] load_address;
    logic        bad_digit;
    logic        last_of_record;
  } result_t;

  // Decoded digit: value and a flag for a character that is not a hex digit
  typedef struct packed {
    logic       bad;
    logic [3:0] value;
  } digit_t;

  function automatic digit_t hex_digit(input logic [7:0] c);
    digit_t d;
    logic [7:0] v;
    d.bad   = 1'b1;
    d.value = 4'h0;
    v       = 8'h00;
    if (c >= CH_0 && c <= CH_9) begin
      v = c - CH_0;
      d.bad = 1'b0;
    end else if (c >= CH_UP_A && c <= CH_UP_F) begin
      v = c - CH_UP_A + DIGIT_TEN;
      d.bad = 1'b0;
    end else if (c >= CH_LO_A && c <= CH_LO_F) begin
      v = c - CH_LO_A + DIGIT_TEN;
      d.bad = 1'b0;
    end
    d.value = v[3:0];
    return d;
  endfunction

endpackage

// ===== hw/rtl/ihex_front.sv =====
// Front end: skips framing characters, decodes hex digits and pairs nibbles into bytes.
// Depends on ihex_pkg; feeds ihex_byte_q.
module ihex_front import ihex_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       char_accept,
  input  logic [7:0] char_in,
  output logic       byte_push,
  output byte_beat_t byte_beat
);

  logic       low_next_r, low_next_nxt;
  logic [3:0] high_nibble_r, high_nibble_nxt;
  logic       high_bad_r, high_bad_nxt;
  logic       skip;
  digit_t     dig;

  assign skip = (char_in == CH_COLON) || (char_in == CH_CR) || (char_in == CH_LF);
  assign dig  = hex_digit(char_in);

  always_comb begin
    low_next_nxt    = low_next_r;
    high_nibble_nxt = high_nibble_r;
    high_bad_nxt    = high_bad_r;
    byte_push       = 1'b0;
    byte_beat.value = {high_nibble_r, dig.value};
    byte_beat.bad   = high_bad_r | dig.bad;
    if (char_accept && !skip) begin
      if (!low_next_r) begin
        // hold the high nibble until its partner arrives
        high_nibble_nxt = dig.value;
        high_bad_nxt    = dig.bad;
        low_next_nxt    = 1'b1;
      end else begin
        low_next_nxt = 1'b0;
        byte_push    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_next_r    <= 1'b0;
      high_nibble_r <= 4'h0;
      high_bad_r    <= 1'b0;
    end else begin
      low_next_r    <= low_next_nxt;
      high_nibble_r <= high_nibble_nxt;
      high_bad_r    <= high_bad_nxt;
    end
  end

endmodule

// ===== hw/rtl/ihex_byte_q.sv =====
// Two-entry queue of decoded bytes between the front and the back.
// Depends on ihex_pkg.
module ihex_byte_q import ihex_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  byte_beat_t push_beat,
  input  logic       pop,
  output logic       full,
  output logic       empty,
  output byte_beat_t head
);

  byte_beat_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== hw/rtl/ihex_back.sv =====
// Back end: record field sequencer, data byte emission and the two-entry result queue.
// Depends on ihex_pkg; takes bytes from ihex_byte_q.
module ihex_back import ihex_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  input  logic       bq_empty,
  input  byte_beat_t bq_head,
  output logic       bq_pop,
  input  logic       res_pop,
  output logic       res_empty,
  output result_t    res_head
);

  localparam logic [2:0] PH_COUNT    = 3'd0;
  localparam logic [2:0] PH_ADDR_HI  = 3'd1;
  localparam logic [2:0] PH_ADDR_LO  = 3'd2;
  localparam logic [2:0] PH_TYPE     = 3'd3;
  localparam logic [2:0] PH_DATA     = 3'd4;
  localparam logic [2:0] PH_CHECKSUM = 3'd5;

  logic        emit_all_r;
  logic [2:0]  phase_r, phase_nxt;
  logic [7:0]  data_count_r, data_count_nxt;
  logic [7:0]  data_left_r, data_left_nxt;
  logic [15:0] rec_addr_r, rec_addr_nxt;
  logic [7:0]  rec_kind_r, rec_kind_nxt;
  logic        finished_r, finished_nxt;

  result_t     oq_mem_r [2];
  logic        oq_wr_r, oq_rd_r;
  logic [1:0]  oq_cnt_r, oq_cnt_nxt;
  logic        oq_push, oq_pop;
  result_t     oq_beat;

  logic        take;
  logic [7:0]  pos;

  assign res_empty = (oq_cnt_r == 2'd0);
  assign res_head  = oq_mem_r[oq_rd_r];
  assign oq_pop    = res_pop && !res_empty;
  // take a byte when the result queue has room, counting a slot freed this cycle
  assign take      = !bq_empty && ((oq_cnt_r != 2'd2) || oq_pop);
  assign bq_pop    = take;
  assign pos       = data_count_r - data_left_r;

  always_comb begin
    phase_nxt      = phase_r;
    data_count_nxt = data_count_r;
    data_left_nxt  = data_left_r;
    rec_addr_nxt   = rec_addr_r;
    rec_kind_nxt   = rec_kind_r;
    finished_nxt   = finished_r;
    oq_push        = 1'b0;
    oq_beat.data_byte      = bq_head.value;
    oq_beat.load_address   = rec_addr_r + {8'h00, pos};
    oq_beat.bad_digit      = bq_head.bad;
    oq_beat.last_of_record = (data_left_r == 8'd1);
    if (take && !finished_r) begin
      unique case (phase_r)
        PH_ADDR_HI: begin
          rec_addr_nxt = {bq_head.value, 8'h00};
          phase_nxt    = PH_ADDR_LO;
        end
        PH_ADDR_LO: begin
          rec_addr_nxt = {rec_addr_r[15:8], bq_head.value};
          phase_nxt    = PH_TYPE;
        end
        PH_TYPE: begin
          rec_kind_nxt = bq_head.value;
          phase_nxt    = (data_left_r != 8'd0) ? PH_DATA : PH_CHECKSUM;
        end
        PH_DATA: begin
          oq_push       = emit_all_r || (rec_kind_r == REC_DATA);
          data_left_nxt = data_left_r - 8'd1;
          if (data_left_r == 8'd1) begin
            phase_nxt = PH_CHECKSUM;
          end
        end
        PH_CHECKSUM: begin
          phase_nxt = PH_COUNT;
          if (rec_kind_r == REC_EOF) begin
            finished_nxt = 1'b1;
          end
        end
        default: begin
          data_count_nxt = bq_head.value;
          data_left_nxt  = bq_head.value;
          phase_nxt      = PH_ADDR_HI;
        end
      endcase
    end
    oq_cnt_nxt = oq_cnt_r + {1'b0, oq_push} - {1'b0, oq_pop};
  end

  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq_mem_r[oq_wr_r] <= oq_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_all_r   <= 1'b1;
      phase_r      <= PH_COUNT;
      data_count_r <= 8'h00;
      data_left_r  <= 8'h00;
      rec_addr_r   <= 16'h0000;
      rec_kind_r   <= 8'h00;
      finished_r   <= 1'b0;
      oq_wr_r      <= 1'b0;
      oq_rd_r      <= 1'b0;
      oq_cnt_r     <= 2'd0;
    end else begin
      if (cfg_wr_en) begin
        emit_all_r <= cfg_wr_data;
      end
      phase_r      <= phase_nxt;
      data_count_r <= data_count_nxt;
      data_left_r  <= data_left_nxt;
      rec_addr_r   <= rec_addr_nxt;
      rec_kind_r   <= rec_kind_nxt;
      finished_r   <= finished_nxt;
      oq_wr_r      <= oq_push ? ~oq_wr_r : oq_wr_r;
      oq_rd_r      <= oq_pop ? ~oq_rd_r : oq_rd_r;
      oq_cnt_r     <= oq_cnt_nxt;
    end
  end

  a_oq_bound: assert property (@(posedge clk) disable iff (!rst_n)
    oq_cnt_r != 2'd3)
    else $error("result queue count out of range");

  a_finished_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    finished_r |=> finished_r)
    else $error("end-of-file state cleared without reset");

  a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != 3'd6 && phase_r != 3'd7)
    else $error("field phase left the record sequence");

  a_data_left: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA) |-> (data_left_r != 8'd0))
    else $error("data phase with no bytes left");

  a_no_emit_done: assert property (@(posedge clk) disable iff (!rst_n)
    finished_r |-> !oq_push)
    else $error("result pushed after end-of-file record");

endmodule

// ===== hw/rtl/intel_hex_data_extractor.sv =====
// Intel HEX data extractor: one character per beat in, one data byte per beat out.
// A data byte's low digit goes from the front into the byte queue, and the record sequencer
// then registers the result into the result queue that drives the out_ ports.
// Throughput: one character per cycle while in_full is low, set by the two-entry byte and result queues.
// Reset: synchronous, active low; clears the parser, the queues, and sets emit_all_r in ihex_back.
// Depends on ihex_pkg, ihex_front, ihex_byte_q and ihex_back.
module intel_hex_data_extractor import ihex_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_ascii_char,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [7:0]  out_data_byte,
  output logic [15:0] out_load_address,
  output logic        out_bad_digit,
  output logic        out_last_of_record
);

  logic       char_accept;
  logic       byte_push;
  byte_beat_t byte_beat;
  logic       bq_full, bq_empty, bq_pop;
  byte_beat_t bq_head;
  result_t    res_head;

  assign in_full     = bq_full;
  assign char_accept = in_push && !bq_full;

  ihex_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .char_accept (char_accept),
    .char_in     (in_ascii_char),
    .byte_push   (byte_push),
    .byte_beat   (byte_beat)
  );

  ihex_byte_q u_byte_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (byte_push),
    .push_beat (byte_beat),
    .pop       (bq_pop),
    .full      (bq_full),
    .empty     (bq_empty),
    .head      (bq_head)
  );

  ihex_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .bq_empty    (bq_empty),
    .bq_head     (bq_head),
    .bq_pop      (bq_pop),
    .res_pop     (out_pop),
    .res_empty   (out_empty),
    .res_head    (res_head)
  );

  assign out_data_byte      = res_head.data_byte;
  assign out_load_address   = res_head.load_address;
  assign out_bad_digit      = res_head.bad_digit;
  assign out_last_of_record = res_head.last_of_record;

endmodule
